FILE: rtl/stencil_hamiltonian_matvec_assert.svh
// Assertion macros used by the checker file.
// Depends on nothing; include once per file that asserts.
`ifndef STENCIL_HAMILTONIAN_MATVEC_ASSERT_SVH
`define STENCIL_HAMILTONIAN_MATVEC_ASSERT_SVH
// implication checked every clock outside reset
`define SHM_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define SHM_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

FILE: rtl/shm_pkg.sv
// Package for the stencil Hamiltonian block: constants, request types, helpers.
// Depends on nothing.
package shm_pkg;
  localparam int GridXDef = 16;
  localparam int GridYDef = 16;
  localparam int GridZDef = 16;
  localparam int NumDimsDef = 3;
  localparam int StencilTermsDef = 3;
  localparam int StoreDepth = 4096;
  localparam int IdxW = 12;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER = 3'd0, CFG_NEAR = 3'd1, CFG_FAR = 3'd2,
    CFG_SCALE_X = 3'd3, CFG_SCALE_Y = 3'd4, CFG_SCALE_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic { REQ_LOAD = 1'b0, REQ_COMPUTE = 1'b1 } req_e;

  // Request queued between front and back, loads and computes in order.
  typedef struct packed {
    logic            is_cmp;
    logic            valid_pt;
    logic [IdxW-1:0] idx;
    logic [31:0]     wave;
    logic [31:0]     pot;
  } job_t;

  // round half up of a Q32.32 product to Q32.16
  function automatic logic signed [47:0] qround(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = p + 64'sd32768;
    return r[63:16];
  endfunction
endpackage

FILE: rtl/shm_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module shm_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/shm_front.sv
// Front end: accepts requests, classifies them and queues them for the back.
// Depends on shm_pkg.
module shm_front #(
  parameter int Points = shm_pkg::StoreDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic                     req_type_i,
  input  logic [shm_pkg::IdxW-1:0] point_index_i,
  input  logic [31:0]              wave_value_i,
  input  logic [31:0]              potential_value_i,
  output shm_pkg::job_t            job_o,
  output logic                     job_valid_o,
  input  logic                     job_take_i
);
  import shm_pkg::*;
  localparam int QDepth = 2;
  job_t       q_q [QDepth];
  job_t       job_in;
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       acc, take;

  assign full_o      = (cnt_q == 2'(QDepth));
  assign acc         = push_i && !full_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign take        = job_take_i && job_valid_o;
  assign job_o       = q_q[rd_q];

  // classify the request
  always_comb begin
    job_in.is_cmp   = (req_e'(req_type_i) == REQ_COMPUTE);
    job_in.valid_pt = ({20'd0, point_index_i} < 32'(Points));
    job_in.idx      = point_index_i;
    job_in.wave     = wave_value_i;
    job_in.pot      = potential_value_i;
  end

  // advance the two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (acc) wr_q <= ~wr_q;
      if (take) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(take);
    end
  end
  always_ff @(posedge clk_i) begin
    if (acc) q_q[wr_q] <= job_in;
  end
endmodule

FILE: rtl/shm_back.sv
// Back end: writes loads, sequences store reads and the multiply-accumulate
// for one point. Depends on shm_pkg.
module shm_back #(
  parameter int GridX = shm_pkg::GridXDef,
  parameter int GridY = shm_pkg::GridYDef,
  parameter int NumDims = shm_pkg::NumDimsDef,
  parameter int StencilTerms = shm_pkg::StencilTermsDef,
  parameter int Points = shm_pkg::StoreDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  shm_pkg::job_t            job_i,
  input  logic                     job_valid_i,
  output logic                     job_take_o,
  output logic                     ram_we_o,
  output logic [shm_pkg::IdxW-1:0] ram_addr_o,
  output logic [31:0]              ram_wave_o,
  output logic [31:0]              ram_pot_o,
  input  logic [31:0]              wave_i,
  input  logic [31:0]              pot_i,
  input  logic [2:0][31:0]         coef_i,
  input  logic [2:0][31:0]         scale_i,
  output logic                     res_valid_o,
  input  logic                     res_take_i,
  output logic [31:0]              result_o,
  output logic                     ovf_o
);
  import shm_pkg::*;
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_XV   = 10'b0000000010, S_VACC = 10'b0000000100,
    S_CACC = 10'b0000001000, S_ADDR = 10'b0000010000, S_MUL  = 10'b0000100000,
    S_ACC  = 10'b0001000000, S_SCL  = 10'b0010000000, S_TADD = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } st_e;
  localparam int Slots = 2 * (StencilTerms - 1);
  localparam int AW = 20;
  localparam logic signed [49:0] SumMax = 50'sd2147483647;
  localparam logic signed [49:0] SumMin = -50'sd2147483648;
  localparam logic signed [50:0] TotMax = 51'sd2147483647;
  localparam logic signed [50:0] TotMin = -51'sd2147483648;

  st_e st_q, st_d;
  logic [IdxW-1:0]    idx_q;
  logic [1:0]         dim_q;
  logic [2:0]         slot_q;
  logic               use_q, oob_q, ovf_q, rv_q, res_ovf_q;
  logic signed [31:0] xi_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] cen_q;
  logic signed [49:0] sum_q;
  logic signed [50:0] tot_q;
  logic [31:0]        res_q;
  logic [AW-1:0]      stride, span, nb_far;
  logic [1:0]         term;
  logic               neg, nb_ok, sum_ovf;
  logic [IdxW-1:0]    nb_addr;
  logic signed [31:0] sum_sat;

  // stride and neighbor address of the current slot, and the saturated sum
  always_comb begin
    unique case (dim_q)
      2'd0:    stride = AW'(1);
      2'd1:    stride = AW'(GridX);
      default: stride = AW'(GridX * GridY);
    endcase
    term    = slot_q[2:1] + 2'd1;
    neg     = slot_q[0];
    span    = term[1] ? {stride[AW-2:0], 1'b0} : stride;
    nb_far  = AW'(idx_q) + span;
    nb_ok   = neg ? (AW'(idx_q) >= span) : (nb_far < AW'(Points));
    nb_addr = neg ? (idx_q - span[IdxW-1:0]) : (idx_q + span[IdxW-1:0]);
    sum_ovf = (sum_q > SumMax) || (sum_q < SumMin);
    sum_sat = (sum_q > SumMax) ? 32'sh7fffffff :
              (sum_q < SumMin) ? 32'sh80000000 : sum_q[31:0];
  end

  assign job_take_o  = (st_q == S_IDLE) && job_valid_i;
  assign ram_we_o    = job_take_o && !job_i.is_cmp;
  assign ram_addr_o  = (st_q == S_IDLE) ? job_i.idx : nb_addr;
  assign ram_wave_o  = job_i.wave;
  assign ram_pot_o   = job_i.pot;
  assign res_valid_o = rv_q;
  assign result_o    = res_q;
  assign ovf_o       = res_ovf_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (job_take_o && job_i.is_cmp) st_d = job_i.valid_pt ? S_XV : S_OUT;
      S_XV:   st_d = S_VACC;
      S_VACC: st_d = S_CACC;
      S_CACC: st_d = S_ADDR;
      S_ADDR: st_d = S_MUL;
      S_MUL:  st_d = S_ACC;
      S_ACC:  st_d = (slot_q == 3'(Slots - 1)) ? S_SCL : S_ADDR;
      S_SCL:  st_d = S_TADD;
      S_TADD: st_d = (dim_q == 2'(NumDims - 1)) ? S_OUT : S_ADDR;
      S_OUT:  if (!rv_q) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // step the sequencer; hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_OUT && !rv_q) rv_q <= 1'b1;
      else if (rv_q && res_take_i) rv_q <= 1'b0;
    end
  end

  // potential and center terms, then one store read, one product and one add per neighbor slot, scaling and result
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        idx_q <= job_i.idx; oob_q <= !job_i.valid_pt; ovf_q <= 1'b0;
        dim_q <= 2'd0; slot_q <= 3'd0;
      end
      S_XV: begin
        xi_q   <= wave_i;
        prod_q <= $signed(pot_i) * $signed(wave_i);
      end
      S_VACC: begin
        tot_q  <= 51'(qround(prod_q));
        prod_q <= $signed(coef_i[0]) * xi_q;
      end
      S_CACC: begin
        cen_q <= qround(prod_q);
        sum_q <= 50'(qround(prod_q));
      end
      S_ADDR: use_q <= nb_ok;
      S_MUL:  prod_q <= $signed(coef_i[term]) * $signed(wave_i);
      S_ACC: begin
        if (use_q) sum_q <= sum_q + 50'(qround(prod_q));
        slot_q <= slot_q + 3'd1;
      end
      S_SCL: begin
        ovf_q  <= ovf_q | sum_ovf;
        prod_q <= $signed(scale_i[dim_q]) * sum_sat;
      end
      S_TADD: begin
        tot_q <= tot_q + 51'(qround(prod_q));
        sum_q <= 50'(cen_q); slot_q <= 3'd0; dim_q <= dim_q + 2'd1;
      end
      S_OUT: begin
        if (!rv_q) begin
          if (oob_q) begin
            res_q <= '0; res_ovf_q <= 1'b0;
          end else if (tot_q > TotMax) begin
            res_q <= 32'h7fffffff; res_ovf_q <= 1'b1;
          end else if (tot_q < TotMin) begin
            res_q <= 32'h80000000; res_ovf_q <= 1'b1;
          end else begin
            res_q <= tot_q[31:0]; res_ovf_q <= ovf_q;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/stencil_hamiltonian_matvec.sv
// Stencil Hamiltonian matrix-vector block, a point at a time from
// single-port stores. Requests pass in order through a two-entry queue; a
// load writes the stores as the back end takes it, a compute reads the
// center point and then does one store read, one 32x32 product and one
// add in turn for every neighbor. The back end takes no new request until
// a compute is through; a waiting result stalls the back end. A compute
// beyond the grid answers zero.
// Depends on shm_pkg, shm_ram, shm_front, shm_back.
module stencil_hamiltonian_matvec #(
  parameter int GridX = shm_pkg::GridXDef,
  parameter int GridY = shm_pkg::GridYDef,
  parameter int GridZ = shm_pkg::GridZDef,
  parameter int NumDims = shm_pkg::NumDimsDef,
  parameter int StencilTerms = shm_pkg::StencilTermsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [11:0] point_index_i,
  input  logic signed [31:0] wave_value_i,
  input  logic signed [31:0] potential_value_i,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] result_value_o,
  output logic        overflow_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import shm_pkg::*;
  localparam int PointsRaw = GridX * GridY * GridZ;
  localparam int Points = (PointsRaw > StoreDepth) ? StoreDepth : PointsRaw;
  logic [2:0][31:0] coef_q;
  logic [2:0][31:0] scale_q;
  logic        job_valid, job_take, res_valid, ram_we;
  job_t        job;
  logic [11:0] ram_addr;
  logic [31:0] ram_wave, ram_pot, wave_rd, pot_rd;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0; scale_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER:  coef_q[0] <= cfg_data_i;
        CFG_NEAR:    coef_q[1] <= cfg_data_i;
        CFG_FAR:     coef_q[2] <= cfg_data_i;
        CFG_SCALE_X: scale_q[0] <= cfg_data_i;
        CFG_SCALE_Y: scale_q[1] <= cfg_data_i;
        CFG_SCALE_Z: scale_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  shm_front #(.Points(Points)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_type_i,
    .point_index_i, .wave_value_i, .potential_value_i, .job_o(job),
    .job_valid_o(job_valid), .job_take_i(job_take)
  );
  shm_ram #(.Width(32), .Depth(StoreDepth)) u_wave (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wave),
    .rdata_o(wave_rd)
  );
  shm_ram #(.Width(32), .Depth(StoreDepth)) u_pot (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_pot),
    .rdata_o(pot_rd)
  );
  shm_back #(.GridX(GridX), .GridY(GridY), .NumDims(NumDims),
             .StencilTerms(StencilTerms), .Points(Points)) u_back (
    .clk_i, .rst_ni, .job_i(job), .job_valid_i(job_valid),
    .job_take_o(job_take), .ram_we_o(ram_we), .ram_addr_o(ram_addr),
    .ram_wave_o(ram_wave), .ram_pot_o(ram_pot),
    .wave_i(wave_rd), .pot_i(pot_rd), .coef_i(coef_q), .scale_i(scale_q),
    .res_valid_o(res_valid), .res_take_i(pop),
    .result_o(result_value_o), .ovf_o(overflow_o)
  );
  assign empty = !res_valid;
endmodule

FILE: rtl/shm_checker.sv
// Port-level checker for the stencil Hamiltonian block, bound to the top.
// Depends on stencil_hamiltonian_matvec_assert.svh.
`include "stencil_hamiltonian_matvec_assert.svh"
module shm_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] result_value_o,
  input logic        overflow_o
);
  `SHM_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_value_o))
  `SHM_ASSERT_NXT(a_hold_ovf, clk_i, rst_ni, !empty && !pop, $stable(overflow_o))
  `SHM_ASSERT_NXT(a_pop, clk_i, rst_ni, !empty && pop, empty)
endmodule

bind stencil_hamiltonian_matvec shm_port_checker u_chk (.*);
